@@ rtl/tat_pkg.sv @@
// Shared types and constants for the TLB address translator.
// No dependencies; used by every module of the block except tat_fifo.
`default_nettype none

package tat_pkg;

	// Field widths
	localparam int VA_W     = 32;
	localparam int PA_W     = 12;
	localparam int VPN_W    = 25;
	localparam int FRAME_W  = 16;
	localparam int STATUS_W = 3;
	localparam int EIDX_IN_W = 4;
	localparam int TSIZE_W  = 5;

	// Defaults for the top-level parameters
	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_PAGE_BYTES = 128;
	localparam int DEF_FRAMES     = 32;

	// Upper bounds over the parameter ranges (64 entries, pages of 16..4096 bytes)
	localparam int SLOT_W = 6;
	localparam int PAGE_W = 28;
	localparam int OFF_W  = 12;

	// Queue depths between the parts
	localparam int CMD_DEPTH = 2;
	localparam int RSP_DEPTH = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FAULT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RO    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BUS   = 3'd4;

	typedef enum logic [1:0] {
		KIND_XLATE = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2,
		SZ_ODD  = 2'd3
	} size_t;

	// Configuration register indexes
	typedef enum logic {
		REG_TRANSLATE_MODE = 1'b0,
		REG_TABLE_SIZE     = 1'b1
	} reg_t;

	typedef enum logic {
		BK_LOOK = 1'b0,
		BK_EXEC = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VA_W-1:0]    virt_addr;
		logic [1:0]         access_size;
		logic               is_write;
		logic [EIDX_IN_W-1:0] entry_index;
		logic [VPN_W-1:0]   entry_vpn;
		logic [FRAME_W-1:0] entry_frame;
		logic               entry_valid;
		logic               entry_read_only;
		logic               entry_use;
		logic               entry_dirty;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PA_W-1:0]     phys_addr;
		logic [VPN_W-1:0]    out_vpn;
		logic [FRAME_W-1:0]  out_frame;
		logic                out_valid;
		logic                out_read_only;
		logic                out_use;
		logic                out_dirty;
	} rsp_t;

	typedef struct packed {
		logic [VPN_W-1:0]   vpn;
		logic [FRAME_W-1:0] frame;
		logic               valid;
		logic               read_only;
		logic               used;
		logic               dirty;
	} entry_t;

	// Classified command from front to back
	typedef struct packed {
		kind_t             op;
		logic              pre_err;   // address error known up front
		logic              assoc;
		logic              is_write;
		logic [SLOT_W-1:0] slot;
		logic              slot_ok;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset;
		entry_t            data;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/tat_fifo.sv @@
// Small synchronous queue with registered storage.
// Generic over the payload type; no package dependency.
`default_nettype none

module tat_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire T     wdata,
	output logic      full,
	input  wire logic rd,
	output T          rdata,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	T                 data_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = data_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tat_front.sv @@
// Front end: takes request transfers and classifies them into commands.
// Depends on tat_pkg.
`default_nettype none

module tat_front #(
	parameter int ENTRIES    = tat_pkg::DEF_ENTRIES,
	parameter int PAGE_BYTES = tat_pkg::DEF_PAGE_BYTES
) (
	input  wire tat_pkg::req_t             req,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic                      translate_mode,
	input  wire logic [tat_pkg::TSIZE_W-1:0] table_size,
	input  wire logic                      cmd_full,
	output logic                           cmd_push,
	output tat_pkg::cmd_t                  cmd
);

	localparam int OFFB = $clog2(PAGE_BYTES);
	localparam int CMP_W = tat_pkg::SLOT_W + 1;
	localparam logic [tat_pkg::VA_W-1:0] OFF_MASK = tat_pkg::VA_W'(PAGE_BYTES - 1);
	localparam logic [tat_pkg::PAGE_W-1:0] ENT_L = tat_pkg::PAGE_W'(ENTRIES);
	localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

	logic [tat_pkg::PAGE_W-1:0] page, tsz, limit;
	logic                       misaligned;

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;

	always_comb begin
		page  = tat_pkg::PAGE_W'(req.virt_addr >> OFFB);
		tsz   = tat_pkg::PAGE_W'(table_size);
		limit = (tsz > ENT_L) ? ENT_L : tsz;

		unique case (tat_pkg::size_t'(req.access_size))
			tat_pkg::SZ_WORD: misaligned = (req.virt_addr[1:0] != 2'b00);
			tat_pkg::SZ_HALF: misaligned = req.virt_addr[0];
			default:          misaligned = 1'b0;
		endcase

		cmd.op             = tat_pkg::kind_t'(req.kind);
		cmd.assoc          = translate_mode;
		cmd.is_write       = req.is_write;
		cmd.page           = page;
		cmd.offset         = tat_pkg::OFF_W'(req.virt_addr & OFF_MASK);
		cmd.data.vpn       = req.entry_vpn;
		cmd.data.frame     = req.entry_frame;
		cmd.data.valid     = req.entry_valid;
		cmd.data.read_only = req.entry_read_only;
		cmd.data.used      = req.entry_use;
		cmd.data.dirty     = req.entry_dirty;
		cmd.slot_ok        = CMP_W'(req.entry_index) < ENT_C;

		if (cmd.op == tat_pkg::KIND_XLATE) begin
			// linear mode indexes by page number; beyond the table is an address error
			cmd.slot    = tat_pkg::SLOT_W'(page);
			cmd.pre_err = misaligned || (!translate_mode && (page >= limit));
		end else begin
			cmd.slot    = tat_pkg::SLOT_W'(req.entry_index);
			cmd.pre_err = 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tat_back.sv @@
// Back end: entry store, associative compare, checks and use/dirty update.
// Depends on tat_pkg.
`default_nettype none

module tat_back #(
	parameter int ENTRIES    = tat_pkg::DEF_ENTRIES,
	parameter int PAGE_BYTES = tat_pkg::DEF_PAGE_BYTES,
	parameter int FRAMES     = tat_pkg::DEF_FRAMES
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tat_pkg::cmd_t cmd,
	input  wire logic    cmd_empty,
	output logic         cmd_pop,
	input  wire logic    rsp_full,
	output logic         rsp_push,
	output tat_pkg::rsp_t rsp
);

	localparam int EIDX_W = $clog2(ENTRIES);
	localparam int OFFB = $clog2(PAGE_BYTES);
	localparam logic [tat_pkg::FRAME_W-1:0] FRAME_LIM = tat_pkg::FRAME_W'(FRAMES);

	tat_pkg::entry_t    store_q [ENTRIES];
	tat_pkg::bk_state_t state_q, state_d;
	tat_pkg::cmd_t      cmd_s1;
	logic [ENTRIES-1:0] match, match_s1;

	logic [EIDX_W-1:0]  hit_idx, sel_idx;
	tat_pkg::entry_t    sel, wr_entry;
	logic               wr_en;
	logic [tat_pkg::VA_W-1:0] pa_full;

	// Associative compare against every slot
	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			match[k] = store_q[k].valid &&
				(tat_pkg::PAGE_W'(store_q[k].vpn) == cmd.page);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tat_pkg::BK_LOOK: if (!cmd_empty) state_d = tat_pkg::BK_EXEC;
			tat_pkg::BK_EXEC: if (!rsp_full) state_d = tat_pkg::BK_LOOK;
			default:          state_d = tat_pkg::BK_LOOK;
		endcase
	end

	// Handshake outputs
	always_comb begin
		cmd_pop  = 1'b0;
		rsp_push = 1'b0;
		unique case (state_q)
			tat_pkg::BK_LOOK: cmd_pop  = !cmd_empty;
			tat_pkg::BK_EXEC: rsp_push = !rsp_full;
			default: ;
		endcase
	end

	// Lowest matching slot wins
	always_comb begin
		hit_idx = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (match_s1[k]) hit_idx = EIDX_W'(k);
		end
		sel_idx = (cmd_s1.op == tat_pkg::KIND_XLATE && cmd_s1.assoc) ?
			hit_idx : cmd_s1.slot[EIDX_W-1:0];
		sel     = store_q[sel_idx];
		pa_full = (tat_pkg::VA_W'(sel.frame) << OFFB) | tat_pkg::VA_W'(cmd_s1.offset);
	end

	// Execute: result and store update
	always_comb begin
		rsp      = '0;
		wr_en    = 1'b0;
		wr_entry = sel;
		unique case (cmd_s1.op)
			tat_pkg::KIND_XLATE: begin
				priority if (cmd_s1.pre_err) begin
					rsp.status = tat_pkg::ST_ADDR;
				end else if (cmd_s1.assoc && (match_s1 == '0)) begin
					rsp.status = tat_pkg::ST_FAULT;
				end else if (!cmd_s1.assoc && !sel.valid) begin
					rsp.status = tat_pkg::ST_FAULT;
				end else if (sel.read_only && cmd_s1.is_write) begin
					rsp.status = tat_pkg::ST_RO;
				end else if (sel.frame >= FRAME_LIM) begin
					rsp.status = tat_pkg::ST_BUS;
				end else begin
					rsp.status     = tat_pkg::ST_OK;
					rsp.phys_addr  = pa_full[tat_pkg::PA_W-1:0];
					wr_en          = 1'b1;
					wr_entry.used  = 1'b1;
					wr_entry.dirty = sel.dirty || cmd_s1.is_write;
				end
			end
			tat_pkg::KIND_LOAD: begin
				wr_en    = cmd_s1.slot_ok;
				wr_entry = cmd_s1.data;
			end
			tat_pkg::KIND_READ: begin
				if (cmd_s1.slot_ok) begin
					rsp.out_vpn       = sel.vpn;
					rsp.out_frame     = sel.frame;
					rsp.out_valid     = sel.valid;
					rsp.out_read_only = sel.read_only;
					rsp.out_use       = sel.used;
					rsp.out_dirty     = sel.dirty;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tat_pkg::BK_LOOK;
			for (int k = 0; k < ENTRIES; k++) begin
				store_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rsp_push && wr_en) begin
				store_q[sel_idx] <= wr_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1   <= cmd;
			match_s1 <= match;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tlb_address_translator_unit.sv @@
// Top level of the TLB address translator: config registers, front end,
// command queue, back end and result queue. Depends on tat_pkg, tat_front,
// tat_fifo and tat_back.
// Usage:
//  - Requests enter as a queue write: req is taken on a clock edge with push
//    high and full low. Kind selects translate, load slot or read slot.
//  - Results leave as a queue read: while empty is low, rsp holds the oldest
//    result; pop high on an edge completes its transfer. Every request gives
//    exactly one result, in order.
//  - Config: cfg_wr_en writes cfg_data into register cfg_index (0 translate
//    mode, 1 table size) at the edge; only while the block is idle.
//  - Path: a request passes the command queue, the back end's registered
//    compare stage and the result queue before it shows on rsp.
//  - The back end takes one request at a time: in its look state it
//    registers the slot compare vector; in its exec state it picks the lowest
//    hit, checks and updates the store, and holds while the result queue is full.
//  - A two-entry command queue separates front and back, a two-entry result
//    queue separates back and receiver. When the receiver stalls, results
//    collect, then the back end holds, then full rises.
//  - Reset: slots cleared (invalid), associative mode, table size 16, queues empty.
`default_nettype none

module tlb_address_translator_unit #(
	parameter int ENTRIES    = tat_pkg::DEF_ENTRIES,
	parameter int PAGE_BYTES = tat_pkg::DEF_PAGE_BYTES,
	parameter int FRAMES     = tat_pkg::DEF_FRAMES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire tat_pkg::req_t               req,
	output logic                             empty,
	input  wire logic                        pop,
	output tat_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_index,
	input  wire logic [tat_pkg::TSIZE_W-1:0] cfg_data
);

	logic                        mode_q;
	logic [tat_pkg::TSIZE_W-1:0] tsize_q;

	// Front to back
	tat_pkg::cmd_t cmd_in, cmd_out;
	logic          cmd_push, cmd_full, cmd_pop, cmd_empty;

	// Back to result queue
	tat_pkg::rsp_t rsp_in;
	logic          rsp_push, rsp_full;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			tsize_q <= tat_pkg::TSIZE_W'(16);
		end else if (cfg_wr_en) begin
			unique case (tat_pkg::reg_t'(cfg_index))
				tat_pkg::REG_TRANSLATE_MODE: mode_q  <= cfg_data[0];
				tat_pkg::REG_TABLE_SIZE:     tsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tat_front #(
		.ENTRIES    (ENTRIES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_front (
		.req            (req),
		.push           (push),
		.full           (full),
		.translate_mode (mode_q),
		.table_size     (tsize_q),
		.cmd_full       (cmd_full),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in)
	);

	tat_fifo #(
		.T     (tat_pkg::cmd_t),
		.DEPTH (tat_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	tat_back #(
		.ENTRIES    (ENTRIES),
		.PAGE_BYTES (PAGE_BYTES),
		.FRAMES     (FRAMES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (rsp_in)
	);

	// Result queue; transfer to the receiver on pop
	tat_fifo #(
		.T     (tat_pkg::rsp_t),
		.DEPTH (tat_pkg::RSP_DEPTH)
	) u_rsp_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rsp_push),
		.wdata  (rsp_in),
		.full   (rsp_full),
		.rd     (pop),
		.rdata  (rsp),
		.empty  (empty)
	);

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for tlb_address_translator_unit.
// Holds its own model of the translation store; depends on tat_pkg and the RTL.
// Directed and random cases of loads, reads and translations in each mode.
`default_nettype none

module tb_top;
	import tat_pkg::*;

	localparam int ENTRIES    = DEF_ENTRIES;
	localparam int PAGE_BYTES = DEF_PAGE_BYTES;
	localparam int FRAMES     = DEF_FRAMES;
	localparam int OFF_BITS   = $clog2(PAGE_BYTES);
	localparam int DRAIN_CYC  = 8;   // drain margin: pipeline plus queue slack

	// DUT connections; every input known from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                full;
	req_t                req       = '0;
	logic                empty;
	logic                pop       = 1'b0;
	rsp_t                rsp;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_index = 1'b0;
	logic [TSIZE_W-1:0]  cfg_data  = '0;

	// Shadow of the block's state and registers
	entry_t              slot_copy [ENTRIES];
	logic                mode_copy;
	logic [TSIZE_W-1:0]  tsize_copy;

	rsp_t                pending_rsp [$];   // expected results, oldest first
	rsp_t                exp_rsp;
	int                  mismatch_cnt = 0;
	bit                  stall_en     = 1'b1;
	logic [VPN_W-1:0]    vpn_pool [8];      // page numbers that loads and lookups share

	tlb_address_translator_unit #(
		.ENTRIES   (ENTRIES),
		.PAGE_BYTES(PAGE_BYTES),
		.FRAMES    (FRAMES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Result of one request, applied to the shadow store in transfer order.
	function automatic rsp_t translate_and_update(input req_t item);
		rsp_t             r;
		logic [VPN_W-1:0] page;
		logic [OFF_W-1:0] off;
		int               hit;
		logic [TSIZE_W-1:0] lim;
		r   = '0;
		hit = -1;
		case (kind_t'(item.kind))
			KIND_XLATE: begin
				page = VPN_W'(item.virt_addr >> OFF_BITS);
				off  = OFF_W'(item.virt_addr % PAGE_BYTES);
				// alignment first; odd size code skips it
				if ((item.access_size == SZ_WORD && item.virt_addr[1:0] != 2'b00) ||
				    (item.access_size == SZ_HALF && item.virt_addr[0])) begin
					r.status = ST_ADDR;
				end else if (mode_copy) begin
					// lowest valid matching slot wins
					for (int k = ENTRIES - 1; k >= 0; k--)
						if (slot_copy[k].valid && slot_copy[k].vpn == page)
							hit = k;
					if (hit < 0)
						r.status = ST_FAULT;
				end else begin
					// linear table, size saturates at the store depth
					lim = (tsize_copy > ENTRIES) ? TSIZE_W'(ENTRIES) : tsize_copy;
					if (page >= lim)
						r.status = ST_ADDR;
					else if (!slot_copy[page].valid)
						r.status = ST_FAULT;
					else
						hit = int'(page);
				end
				if (hit >= 0) begin
					if (slot_copy[hit].read_only && item.is_write) begin
						r.status = ST_RO;
					end else if (slot_copy[hit].frame >= FRAMES) begin
						r.status = ST_BUS;
					end else begin
						slot_copy[hit].used = 1'b1;
						if (item.is_write)
							slot_copy[hit].dirty = 1'b1;
						r.phys_addr = PA_W'(slot_copy[hit].frame * PAGE_BYTES + off);
					end
				end
			end
			KIND_LOAD: begin
				slot_copy[item.entry_index] = '{item.entry_vpn, item.entry_frame,
					item.entry_valid, item.entry_read_only, item.entry_use, item.entry_dirty};
			end
			KIND_READ: begin
				r.out_vpn       = slot_copy[item.entry_index].vpn;
				r.out_frame     = slot_copy[item.entry_index].frame;
				r.out_valid     = slot_copy[item.entry_index].valid;
				r.out_read_only = slot_copy[item.entry_index].read_only;
				r.out_use       = slot_copy[item.entry_index].used;
				r.out_dirty     = slot_copy[item.entry_index].dirty;
			end
			default: ;   // unknown kind: no change, all-zero result
		endcase
		return r;
	endfunction

	function automatic req_t make_xlate(input logic [VA_W-1:0] va, input size_t sz,
	                                    input logic wr);
		req_t r;
		r             = '0;
		r.kind        = KIND_XLATE;
		r.virt_addr   = va;
		r.access_size = sz;
		r.is_write    = wr;
		return r;
	endfunction

	function automatic req_t make_load(input logic [3:0] idx, input logic [VPN_W-1:0] vpn,
	                                   input logic [FRAME_W-1:0] frame, input logic v,
	                                   input logic ro);
		req_t r;
		r                 = '0;
		r.kind            = KIND_LOAD;
		r.entry_index     = idx;
		r.entry_vpn       = vpn;
		r.entry_frame     = frame;
		r.entry_valid     = v;
		r.entry_read_only = ro;
		return r;
	endfunction

	function automatic req_t make_read(input logic [3:0] idx);
		req_t r;
		r             = '0;
		r.kind        = KIND_READ;
		r.entry_index = idx;
		return r;
	endfunction

	// Page numbers: half from the shared pool, some small (around the linear table bound), some wide random.
	function automatic logic [VPN_W-1:0] pick_page();
		int c;
		c = $urandom_range(9);
		if (c < 5)
			return vpn_pool[$urandom_range(7)];
		else if (c < 8)
			return VPN_W'($urandom_range(ENTRIES + 1));
		return VPN_W'($urandom());
	endfunction

	function automatic req_t rand_item();
		req_t r;
		int   c;
		// don't-care fields random too so every bit toggles
		r.virt_addr       = $urandom();
		r.access_size     = 2'($urandom_range(3));
		r.is_write        = 1'($urandom_range(1));
		r.entry_index     = 4'($urandom_range(ENTRIES - 1));
		r.entry_vpn       = VPN_W'($urandom());
		r.entry_frame     = FRAME_W'($urandom());
		r.entry_valid     = 1'($urandom_range(1));
		r.entry_read_only = 1'($urandom_range(1));
		r.entry_use       = 1'($urandom_range(1));
		r.entry_dirty     = 1'($urandom_range(1));
		c = $urandom_range(99);
		if (c < 45) begin
			r.kind = KIND_XLATE;
			if ($urandom_range(9) != 0)
				r.virt_addr = (VA_W'(pick_page()) << OFF_BITS) |
				              VA_W'($urandom_range(PAGE_BYTES - 1));
		end else if (c < 75) begin
			r.kind            = KIND_LOAD;
			r.entry_vpn       = pick_page();
			r.entry_valid     = ($urandom_range(9) < 8);
			r.entry_read_only = ($urandom_range(9) < 3);
			if ($urandom_range(9) < 8)
				r.entry_frame = FRAME_W'($urandom_range(FRAMES + 8));
		end else if (c < 94) begin
			r.kind = KIND_READ;
		end else begin
			r.kind = KIND_NONE;
		end
		return r;
	endfunction

	// One input transfer; push stays high across back-to-back items.
	task automatic send(input req_t item);
		while (stall_en && $urandom_range(99) < 23) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req  <= item;
		do @(posedge clk); while (full);
		pending_rsp.push_back(translate_and_update(item));
	endtask

	// Stop pushing and let every outstanding result come back.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_reg(input reg_t idx, input logic [TSIZE_W-1:0] val);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TRANSLATE_MODE)
			mode_copy = val[0];
		else
			tsize_copy = val;
	endtask

	task automatic send_random(input int n);
		repeat (n) send(rand_item());
	endtask

	// Store is empty after reset; unknown kind is a no-op.
	task automatic test_reset_state();
		send(make_read(4'(ENTRIES - 1)));
		send(make_xlate('0, SZ_BYTE, 1'b0));   // nothing valid: page fault
		send(req_t'('1));                       // all ones = unknown kind
	endtask

	// Associative search: widest page number, lowest slot wins, invalid slot misses.
	task automatic test_assoc_lookup();
		send(make_load(4'd1, '1, FRAME_W'(FRAMES - 1), 1'b1, 1'b0));
		send(make_load(4'd3, VPN_W'(5), FRAME_W'(9), 1'b1, 1'b0));
		send(make_load(4'd2, VPN_W'(5), FRAME_W'(7), 1'b1, 1'b0));
		send(make_load(4'd4, VPN_W'(6), FRAME_W'(3), 1'b0, 1'b0));
		send(make_xlate('1, SZ_BYTE, 1'b1));   // top address -> top physical byte
		send(make_xlate((VA_W'(5) << OFF_BITS) | 3, SZ_BYTE, 1'b0));
		send(make_xlate(VA_W'(6) << OFF_BITS, SZ_BYTE, 1'b0));
		send(make_read(4'd2));
	endtask

	// Check order: alignment, missing, read-only, frame range; odd size unchecked.
	task automatic test_access_checks();
		send(make_load(4'd5, VPN_W'(7), FRAME_W'(FRAMES + 8), 1'b1, 1'b1));
		send(make_xlate(VA_W'(7) << OFF_BITS, SZ_WORD, 1'b1));   // read-only before bus
		send(make_xlate(VA_W'(7) << OFF_BITS, SZ_WORD, 1'b0));   // frame out of range
		send(make_xlate((VA_W'(5) << OFF_BITS) | 1, SZ_HALF, 1'b0));
		send(make_xlate((VA_W'(5) << OFF_BITS) | 2, SZ_WORD, 1'b0));
		send(make_xlate((VA_W'(5) << OFF_BITS) | 3, SZ_ODD, 1'b1));
		send(make_read(4'd2));                                    // use and dirty now set
	endtask

	// Linear mode: empty table, small table bound, oversized table saturating.
	task automatic test_linear_table();
		set_reg(REG_TRANSLATE_MODE, 5'b11110);   // only bit 0 counts
		set_reg(REG_TABLE_SIZE, '0);
		send(make_xlate('0, SZ_BYTE, 1'b0));
		set_reg(REG_TABLE_SIZE, 5'd3);
		send(make_xlate(VA_W'(2) << OFF_BITS, SZ_HALF, 1'b0));
		send(make_xlate(VA_W'(3) << OFF_BITS, SZ_BYTE, 1'b0));
		set_reg(REG_TABLE_SIZE, '1);
		send(make_xlate(VA_W'(ENTRIES - 1) << OFF_BITS, SZ_BYTE, 1'b0));
		send(make_xlate(VA_W'(ENTRIES) << OFF_BITS, SZ_BYTE, 1'b0));
	endtask

	task automatic test_random_assoc();
		set_reg(REG_TRANSLATE_MODE, 5'b10101);
		set_reg(REG_TABLE_SIZE, TSIZE_W'(ENTRIES));
		send_random(300);
	endtask

	task automatic test_random_linear();
		logic [TSIZE_W-1:0] sizes [4];
		sizes = '{'0, '1, TSIZE_W'(ENTRIES), TSIZE_W'($urandom_range(1, ENTRIES - 1))};
		set_reg(REG_TRANSLATE_MODE, '0);
		foreach (sizes[i]) begin
			set_reg(REG_TABLE_SIZE, sizes[i]);
			send_random(75);
		end
	endtask

	// No idling on either side: back-to-back transfers.
	task automatic test_random_burst();
		set_reg(REG_TRANSLATE_MODE, 5'd1);
		stall_en = 1'b0;
		send_random(150);
		stall_en = 1'b1;
	endtask

	// Receiver: random stalls on pop; each accepted result checked against the oldest one.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_rsp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result with none expected: %p", $realtime, rsp);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.status !== exp_rsp.status || rsp.phys_addr !== exp_rsp.phys_addr ||
				    rsp.out_vpn !== exp_rsp.out_vpn || rsp.out_frame !== exp_rsp.out_frame ||
				    rsp.out_valid !== exp_rsp.out_valid ||
				    rsp.out_read_only !== exp_rsp.out_read_only ||
				    rsp.out_use !== exp_rsp.out_use || rsp.out_dirty !== exp_rsp.out_dirty) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$write("%0t: mismatch status %0h/%0h pa %0h/%0h vpn %0h/%0h ",
						       $realtime, exp_rsp.status, rsp.status,
						       exp_rsp.phys_addr, rsp.phys_addr,
						       exp_rsp.out_vpn, rsp.out_vpn);
						$display("frame %0h/%0h v %b/%b ro %b/%b u %b/%b d %b/%b (exp/got)",
						         exp_rsp.out_frame, rsp.out_frame,
						         exp_rsp.out_valid, rsp.out_valid,
						         exp_rsp.out_read_only, rsp.out_read_only,
						         exp_rsp.out_use, rsp.out_use, exp_rsp.out_dirty, rsp.out_dirty);
					end
				end
			end
		end
		pop <= stall_en ? ($urandom_range(99) >= 23) : 1'b1;
	end

	initial begin
		foreach (slot_copy[i])
			slot_copy[i] = '0;
		mode_copy   = 1'b1;
		tsize_copy  = TSIZE_W'(ENTRIES);
		vpn_pool[0] = '0;
		vpn_pool[1] = '1;
		vpn_pool[2] = VPN_W'(2);
		vpn_pool[3] = VPN_W'($urandom_range(ENTRIES - 1));
		for (int i = 4; i < 8; i++)
			vpn_pool[i] = VPN_W'($urandom());

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_assoc_lookup();
		test_access_checks();
		test_random_assoc();
		test_linear_table();
		test_random_linear();
		test_random_burst();

		wait_idle();
		if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/tat_pkg.sv
rtl/tat_fifo.sv
rtl/tat_front.sv
rtl/tat_back.sv
rtl/tlb_address_translator_unit.sv
verif/tb_top.sv
